@@ rtl/stt_pkg.sv @@
// stt_pkg: shared types and constants for the search transposition table
// no dependencies
`timescale 1ns / 1ps

package stt_pkg;

  localparam logic [2:0] ACT_STORE = 3'd0;
  localparam logic [2:0] ACT_PROBE = 3'd1;
  localparam logic [2:0] ACT_PV    = 3'd2;
  localparam logic [2:0] ACT_CLEAR = 3'd3;
  localparam logic [2:0] ACT_COUNT = 3'd4;

  localparam logic [1:0] FLAG_UPPER = 2'd0;
  localparam logic [1:0] FLAG_LOWER = 2'd1;
  localparam logic [1:0] FLAG_EXACT = 2'd2;

  localparam logic CFG_ENTRIES = 1'b0;
  localparam logic CFG_MATE    = 1'b1;

  localparam int SCORE_MAX = 32767;
  localparam int PERMILL   = 1000;

  // n / 1000 as (n * ceil(2^27 / 1000)) >> 27, exact for n below 2^17
  localparam int PERMILL_RECIP = 134218;
  localparam int PERMILL_SHIFT = 27;

  typedef enum logic [3:0] {
    ST_INIT,    // clearing pass after reset
    ST_IDLE,
    ST_MOD,     // serial key modulo
    ST_RD,      // memory read issued
    ST_RDW,     // read data valid
    ST_CLR,     // clear sweep
    ST_CDIV,    // entries / 1000
    ST_CNT,     // occupancy sweep
    ST_CNTW,
    ST_OUT
  } state_t;

endpackage

@@ rtl/search_transposition_table_top.sv @@
// search_transposition_table_top: direct-mapped always-replace search table
// depends on stt_pkg, stt_ram, stt_moddiv
`timescale 1ns / 1ps

// Usage
// Input channel in_valid / in_stall carries one action with its fields; the
// result channel out_valid / out_stall returns exactly one result per action.
// The block takes one action at a time: in_stall is high from the transfer
// until the result has been taken; the next input is taken in the next cycle.
// Store, probe and pv probe: the key is reduced modulo the entry count by a
// serial divider, one key bit a cycle; then a store writes the entry, and a
// probe or pv probe reads the entry and compares its key.
// Clear sweeps the table one entry a cycle.
// Occupancy count: entries/1000 by reciprocal multiply, then one entry per
// cycle once the first registered read has returned.
// After reset a clearing pass over all TABLE_ENTRIES entries runs before the first
// input transfer is taken; configuration writes are taken throughout.
// While out_stall is high the result is held and no new input is taken.
module search_transposition_table_top #(
  parameter int TABLE_ENTRIES = 65536,
  parameter int DEPTH_LIMIT   = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [63:0] in_key,
  input  logic [15:0] in_move_code,
  input  logic signed [15:0] in_score_in,
  input  logic [1:0]  in_bound_flag,
  input  logic [6:0]  in_search_depth,
  input  logic signed [15:0] in_alpha,
  input  logic signed [15:0] in_beta,
  input  logic [5:0]  in_ply,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_key_matched,
  output logic        out_cutoff,
  output logic [15:0] out_move_out,
  output logic signed [15:0] out_score_out,
  output logic [16:0] out_occupied_count
);

  localparam int AW  = $clog2(TABLE_ENTRIES);
  localparam int NW  = AW + 1;
  localparam int DVW = 25;
  localparam int EW  = 64 + 16 + 16 + 7 + 2;
  localparam int RST_ENTRIES = (TABLE_ENTRIES < 65536) ? TABLE_ENTRIES : 65536;

  stt_pkg::state_t state_r, state_nxt;

  logic [16:0] entries_r;
  logic [14:0] mate_r;

  // input item registers
  logic [2:0]  act_r;
  logic [63:0] key_r;
  logic [15:0] mv_r;
  logic signed [15:0] sc_r, al_r, be_r;
  logic [1:0]  fl_r;
  logic [6:0]  dp_r;
  logic [5:0]  ply_r;

  logic [AW-1:0] addr_r, addr_nxt;
  logic [NW-1:0] lim_r, lim_nxt;
  logic [16:0]   cnt_r, cnt_nxt;

  logic        om_r, om_nxt, oc_r, oc_nxt;
  logic [15:0] omv_r, omv_nxt;
  logic signed [15:0] osc_r, osc_nxt;
  logic [16:0] ocnt_r, ocnt_nxt;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= 17'(RST_ENTRIES);
      mate_r    <= 15'd29000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        stt_pkg::CFG_ENTRIES: entries_r <= cfg_data;
        stt_pkg::CFG_MATE:    mate_r    <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // effective modulus
  logic [NW-1:0] modn;
  always_comb begin
    if (entries_r == '0) begin
      modn = NW'(1);
    end else if ({8'd0, entries_r} > 25'(TABLE_ENTRIES)) begin
      modn = NW'(TABLE_ENTRIES);
    end else begin
      modn = NW'(entries_r);
    end
  end

  // entries / 1000 by reciprocal multiply
  logic [34:0]   cdiv_prod;
  logic [NW-1:0] cdiv_lim;
  assign cdiv_prod = 35'(modn) * 35'(stt_pkg::PERMILL_RECIP);
  assign cdiv_lim  = NW'(cdiv_prod >> stt_pkg::PERMILL_SHIFT);

  // shared serial divider: key mod n
  logic           div_start, div_done;
  logic [DVW-1:0] div_den, div_rem;
  stt_moddiv #(.NBITS(64), .DBITS(DVW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(in_key),
    .divisor(div_den), .done(div_done), .remainder(div_rem)
  );
  assign div_den = DVW'(modn);

  // table memory
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [EW-1:0] ram_wd, ram_rd;
  stt_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd)
  );

  logic [63:0] e_key;
  logic [15:0] e_mv;
  logic signed [15:0] e_sc;
  logic [6:0]  e_dp;
  logic [1:0]  e_fl;
  assign {e_key, e_mv, e_sc, e_dp, e_fl} = ram_rd;

  // store and probe scores with mate push/pull by ply, saturated; store depth clamped
  logic signed [17:0] st_s, pr_s, mth;
  logic signed [15:0] st_sat, pr_sat;
  logic [6:0] st_dp;
  always_comb begin
    mth = {3'b0, mate_r};
    st_s = 18'(sc_r);
    if (st_s > mth) st_s = st_s + 18'(ply_r);
    else if (st_s < -mth) st_s = st_s - 18'(ply_r);
    if (st_s > 18'sd32767) st_sat = 16'sd32767;
    else if (st_s < -18'sd32767) st_sat = -16'sd32767;
    else st_sat = st_s[15:0];
    pr_s = 18'(e_sc);
    if (pr_s > mth) pr_s = pr_s - 18'(ply_r);
    else if (pr_s < -mth) pr_s = pr_s + 18'(ply_r);
    if (pr_s > 18'sd32767) pr_sat = 16'sd32767;
    else if (pr_s < -18'sd32767) pr_sat = -16'sd32767;
    else pr_sat = pr_s[15:0];
    st_dp = (dp_r > 7'(DEPTH_LIMIT)) ? 7'(DEPTH_LIMIT) : dp_r;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    lim_nxt   = lim_r;
    cnt_nxt   = cnt_r;
    om_nxt = om_r; oc_nxt = oc_r; omv_nxt = omv_r; osc_nxt = osc_r;
    ocnt_nxt  = ocnt_r;
    div_start = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = addr_r;
    ram_wd    = '0;
    unique case (state_r)
      stt_pkg::ST_INIT, stt_pkg::ST_CLR: begin
        ram_we   = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == AW'(TABLE_ENTRIES - 1)) begin
          state_nxt = (state_r == stt_pkg::ST_INIT) ? stt_pkg::ST_IDLE : stt_pkg::ST_OUT;
        end
      end
      stt_pkg::ST_IDLE: begin
        om_nxt = 1'b0; oc_nxt = 1'b0; omv_nxt = '0; osc_nxt = '0; ocnt_nxt = '0;
        if (in_valid) begin
          priority if (in_action == stt_pkg::ACT_STORE || in_action == stt_pkg::ACT_PROBE
                       || in_action == stt_pkg::ACT_PV) begin
            state_nxt = stt_pkg::ST_MOD;
            div_start = 1'b1;
          end else if (in_action == stt_pkg::ACT_CLEAR) begin
            state_nxt = stt_pkg::ST_CLR;
            addr_nxt  = '0;
          end else if (in_action == stt_pkg::ACT_COUNT) begin
            state_nxt = stt_pkg::ST_CDIV;
          end else begin
            state_nxt = stt_pkg::ST_OUT;
          end
        end
      end
      stt_pkg::ST_MOD: begin
        if (div_done) begin
          addr_nxt  = div_rem[AW-1:0];
          state_nxt = stt_pkg::ST_RD;
        end
      end
      stt_pkg::ST_RD: begin
        if (act_r == stt_pkg::ACT_STORE) begin
          ram_we    = 1'b1;
          ram_wd    = {key_r, mv_r, st_sat, st_dp, fl_r};
          state_nxt = stt_pkg::ST_OUT;
        end else begin
          state_nxt = stt_pkg::ST_RDW;
        end
      end
      stt_pkg::ST_RDW: begin
        state_nxt = stt_pkg::ST_OUT;
        if (e_key == key_r) begin
          om_nxt  = 1'b1;
          omv_nxt = e_mv;
          if (act_r == stt_pkg::ACT_PROBE && e_dp >= dp_r) begin
            priority if (e_fl == stt_pkg::FLAG_UPPER) begin
              if (pr_sat <= al_r) begin oc_nxt = 1'b1; osc_nxt = al_r; end
            end else if (e_fl == stt_pkg::FLAG_LOWER) begin
              if (pr_sat >= be_r) begin oc_nxt = 1'b1; osc_nxt = be_r; end
            end else if (e_fl == stt_pkg::FLAG_EXACT) begin
              oc_nxt = 1'b1; osc_nxt = pr_sat;
            end
          end
        end
      end
      stt_pkg::ST_CDIV: begin
        lim_nxt  = cdiv_lim;
        addr_nxt = '0;
        cnt_nxt  = '0;
        state_nxt = (cdiv_lim == '0) ? stt_pkg::ST_OUT : stt_pkg::ST_CNT;
      end
      stt_pkg::ST_CNT: begin
        // address addr_r issued; data arrives next cycle
        state_nxt = stt_pkg::ST_CNTW;
      end
      stt_pkg::ST_CNTW: begin
        if (e_key != '0) cnt_nxt = cnt_r + 1'b1;
        if (NW'(addr_r) + NW'(1) >= lim_r) begin
          ocnt_nxt  = (e_key != '0) ? cnt_r + 1'b1 : cnt_r;
          state_nxt = stt_pkg::ST_OUT;
        end else begin
          addr_nxt  = addr_r + 1'b1;
          ram_addr  = addr_r + 1'b1;
          state_nxt = stt_pkg::ST_CNTW;
        end
      end
      stt_pkg::ST_OUT: begin
        if (!out_stall) state_nxt = stt_pkg::ST_IDLE;
      end
      default: state_nxt = stt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stt_pkg::ST_INIT;
      addr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
    end
    lim_r <= lim_nxt; cnt_r <= cnt_nxt;
    om_r <= om_nxt; oc_r <= oc_nxt; omv_r <= omv_nxt; osc_r <= osc_nxt;
    ocnt_r <= ocnt_nxt;
    if (state_r == stt_pkg::ST_IDLE && in_valid) begin
      act_r <= in_action; key_r <= in_key; mv_r <= in_move_code;
      sc_r <= in_score_in; fl_r <= in_bound_flag; dp_r <= in_search_depth;
      al_r <= in_alpha; be_r <= in_beta; ply_r <= in_ply;
    end
  end

  assign in_stall  = (state_r != stt_pkg::ST_IDLE);
  assign out_valid = (state_r == stt_pkg::ST_OUT);
  assign out_key_matched    = om_r;
  assign out_cutoff         = oc_r;
  assign out_move_out       = omv_r;
  assign out_score_out      = osc_r;
  assign out_occupied_count = ocnt_r;

`ifndef SYNTHESIS
  // no input transfer while a result waits
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");
  // cutoff only with a key match
  a_cut: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cutoff |-> out_key_matched) else $error("cutoff without match");
  // a held result stays valid and its score stable
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_score_out))
    else $error("stalled result changed");
`endif

endmodule

@@ rtl/stt_ram.sv @@
// stt_ram: generic single port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module stt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, and registered read of the addressed word (old data on a write)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/stt_moddiv.sv @@
// stt_moddiv: restoring serial divider, one dividend bit per cycle
// depends on nothing outside this file
`timescale 1ns / 1ps

module stt_moddiv #(
  parameter int NBITS = 64,
  parameter int DBITS = 25
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NBITS-1:0] dividend,
  input  logic [DBITS-1:0] divisor,
  output logic             done,
  output logic [DBITS-1:0] remainder
);

  localparam int CW = $clog2(NBITS + 1);

  logic [NBITS-1:0] num_r, num_nxt;
  logic [DBITS-1:0] rem_r, rem_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DBITS:0]   trial;

  // load on start, else one shift and subtract step
  always_comb begin
    trial    = {rem_r, num_r[NBITS-1]};
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      num_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CW'(NBITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = DBITS'(trial - {1'b0, divisor});
        num_nxt = {num_r[NBITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DBITS-1:0];
        num_nxt = {num_r[NBITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = busy_r && (cnt_r == CW'(1));
  assign remainder = rem_nxt;

endmodule
